>>> rtl/core/rational_arith_reduce_defines.svh
// Assertion macros for the rational reduce RTL.
`ifndef RATIONAL_ARITH_REDUCE_DEFINES_SVH
`define RATIONAL_ARITH_REDUCE_DEFINES_SVH

`ifndef ASSERT_OFF

`define RAR_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rational_arith_reduce: same-cycle check failed");

`define RAR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rational_arith_reduce: next-cycle check failed");

`else

`define RAR_ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define RAR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/core/rar_pkg.sv
`default_nettype none

package rar_pkg;

   localparam int OPERAND_W = 16;
   localparam int DEN_W     = OPERAND_W - 1;
   localparam int PROD_W    = 2 * OPERAND_W;
   localparam int MAG_W     = 2 * OPERAND_W - 1;
   localparam int RES_NUM_W = 32;
   localparam int RES_DEN_W = 31;
   localparam int MUL_CNT_W = $clog2(OPERAND_W + 1);
   localparam int DIV_CNT_W = $clog2(MAG_W + 1);
   localparam int SHIFT_W   = $clog2(MAG_W);

   typedef logic [OPERAND_W-1:0] operand_type;
   typedef logic [DEN_W-1:0]     den_type;
   typedef logic [PROD_W-1:0]    prod_type;
   typedef logic [MAG_W-1:0]     mag_type;
   typedef logic [RES_NUM_W-1:0] res_num_type;
   typedef logic [RES_DEN_W-1:0] res_den_type;
   typedef logic [MUL_CNT_W-1:0] mul_cnt_type;
   typedef logic [DIV_CNT_W-1:0] div_cnt_type;
   typedef logic [SHIFT_W-1:0]   shift_type;

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_COMB,
      ST_GCD,
      ST_DIV,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

>>> rtl/core/rar_mul.sv
`default_nettype none

module rar_mul (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   input  wire rar_pkg::operand_type mcand,
   input  wire rar_pkg::operand_type mplier,
   output logic                  done,
   output rar_pkg::prod_type     product
);

   logic                      busy_ff, busy_in;
   rar_pkg::mul_cnt_type      cnt_ff, cnt_in;
   rar_pkg::operand_type      mcand_ff, mcand_in;
   logic [rar_pkg::PROD_W:0]  acc_ff, acc_in;
   logic [rar_pkg::OPERAND_W:0] hi_sum;

   assign hi_sum = acc_ff[rar_pkg::PROD_W:rar_pkg::OPERAND_W]
                 + {1'b0, (acc_ff[0] ? mcand_ff : '0)};

   always_comb begin
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      mcand_in = mcand_ff;
      acc_in   = acc_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         mcand_in = mcand;
         acc_in   = {{(rar_pkg::OPERAND_W + 1){1'b0}}, mplier};
      end else if (busy_ff) begin
         // add and shift one multiplier bit
         acc_in = {1'b0, hi_sum, acc_ff[rar_pkg::OPERAND_W-1:1]};
         cnt_in = cnt_ff + rar_pkg::mul_cnt_type'(1);
         if (cnt_ff == rar_pkg::mul_cnt_type'(rar_pkg::OPERAND_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      acc_ff   <= acc_in;
   end

   assign done    = !busy_ff;
   assign product = acc_ff[rar_pkg::PROD_W-1:0];

endmodule

`default_nettype wire

>>> rtl/core/rar_gcd.sv
`default_nettype none

module rar_gcd (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   input  wire rar_pkg::mag_type x_init,
   input  wire rar_pkg::mag_type y_init,
   output logic                 done,
   output rar_pkg::mag_type     g
);

   logic                busy_ff, busy_in;
   logic                phase_ff, phase_in;
   rar_pkg::mag_type    x_ff, x_in;
   rar_pkg::mag_type    y_ff, y_in;
   rar_pkg::shift_type  k_ff, k_in;

   always_comb begin
      busy_in  = busy_ff;
      phase_in = phase_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      k_in     = k_ff;
      if (start) begin
         busy_in  = 1'b1;
         phase_in = 1'b0;
         x_in     = x_init;
         y_in     = y_init;
         k_in     = '0;
      end else if (busy_ff && !phase_ff) begin
         if (x_ff == y_ff) begin
            phase_in = 1'b1;
         end else if (!x_ff[0] && !y_ff[0]) begin
            x_in = x_ff >> 1;
            y_in = y_ff >> 1;
            k_in = k_ff + rar_pkg::shift_type'(1);
         end else if (!x_ff[0]) begin
            x_in = x_ff >> 1;
         end else if (!y_ff[0]) begin
            y_in = y_ff >> 1;
         end else if (x_ff > y_ff) begin
            x_in = x_ff - y_ff;
         end else begin
            y_in = y_ff - x_ff;
         end
      end else if (busy_ff) begin
         // restore common factors of two
         if (k_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            x_in = x_ff << 1;
            k_in = k_ff - rar_pkg::shift_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= 1'b0;
         k_ff     <= '0;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
   end

   assign done = !busy_ff;
   assign g    = x_ff;

endmodule

`default_nettype wire

>>> rtl/core/rar_div.sv
`default_nettype none

module rar_div (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   input  wire rar_pkg::mag_type dividend,
   input  wire rar_pkg::mag_type divisor,
   output logic                 done,
   output rar_pkg::mag_type     quotient
);

   logic                     busy_ff, busy_in;
   rar_pkg::div_cnt_type     cnt_ff, cnt_in;
   rar_pkg::mag_type         rem_ff, rem_in;
   rar_pkg::mag_type         quo_ff, quo_in;
   rar_pkg::mag_type         dvs_ff, dvs_in;
   logic [rar_pkg::MAG_W:0]  trial;
   logic [rar_pkg::MAG_W:0]  diff;

   assign trial = {rem_ff, quo_ff[rar_pkg::MAG_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // one quotient bit per cycle, restoring
         if (!diff[rar_pkg::MAG_W]) begin
            rem_in = diff[rar_pkg::MAG_W-1:0];
            quo_in = {quo_ff[rar_pkg::MAG_W-2:0], 1'b1};
         end else begin
            rem_in = trial[rar_pkg::MAG_W-1:0];
            quo_in = {quo_ff[rar_pkg::MAG_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + rar_pkg::div_cnt_type'(1);
         if (cnt_ff == rar_pkg::div_cnt_type'(rar_pkg::MAG_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = !busy_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

>>> rtl/core/rational_arith_reduce.sv
// Each request runs serial multiplies, then a binary gcd and a division of the
// numerator and denominator by the gcd; a zero or divide-by-zero result skips the
// gcd and the division, and a gcd of one skips the division. The block takes one
// word at a time: the next request is taken the cycle after the response enters
// the output register, and a response not taken holds the block. Reset is
// synchronous and clears control state only.
`default_nettype none

`include "rational_arith_reduce_defines.svh"

module rational_arith_reduce (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  wire [1:0]                req_command,
   input  wire rar_pkg::operand_type req_a_num,
   input  wire rar_pkg::den_type    req_a_den,
   input  wire rar_pkg::operand_type req_b_num,
   input  wire rar_pkg::den_type    req_b_den,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output rar_pkg::res_num_type     rsp_res_num,
   output rar_pkg::res_den_type     rsp_res_den,
   output logic                     rsp_reduced,
   output logic                     rsp_div_zero
);

   rar_pkg::state_type    state_ff, state_in;
   rar_pkg::cmd_type      cmd_ff;
   logic                  neg1_ff, neg2_ff;

   logic                  mul_start, gcd_start, div_start, rsp_load;
   logic                  mul_a_done, mul_b_done, mul_c_done;
   rar_pkg::prod_type     prod_a, prod_b, prod_c;
   logic                  gcd_done, div_n_done, div_d_done;
   rar_pkg::mag_type      gcd_g, quo_n, quo_d;

   rar_pkg::operand_type  abs1, abs2, d1, d2;
   rar_pkg::operand_type  mul_a_y, mul_c_y;
   logic                  is_addsub, sign_b;
   rar_pkg::mag_type      mag_c, den_c;
   logic                  neg_c, num_zero, den_zero;

   rar_pkg::mag_type      mag_ff, den_ff;
   logic                  neg_ff, red_ff, dz_ff;
   rar_pkg::mag_type      res_mag, res_dm;

   logic                  rsp_valid_ff;
   rar_pkg::res_num_type  rsp_res_num_ff;
   rar_pkg::res_den_type  rsp_res_den_ff;
   logic                  rsp_reduced_ff, rsp_div_zero_ff;

   // operand preparation on the request word
   assign abs1 = req_a_num[rar_pkg::OPERAND_W-1] ? (~req_a_num + rar_pkg::operand_type'(1))
                                                 : req_a_num;
   assign abs2 = req_b_num[rar_pkg::OPERAND_W-1] ? (~req_b_num + rar_pkg::operand_type'(1))
                                                 : req_b_num;
   assign d1 = (req_a_num == '0) ? rar_pkg::operand_type'(1) : {1'b0, req_a_den};
   assign d2 = (req_b_num == '0) ? rar_pkg::operand_type'(1) : {1'b0, req_b_den};
   assign mul_a_y = (rar_pkg::cmd_type'(req_command) == rar_pkg::CMD_MUL) ? abs2 : d2;
   assign mul_c_y = (rar_pkg::cmd_type'(req_command) == rar_pkg::CMD_DIV) ? abs2 : d2;

   rar_mul u_mul_a (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (abs1),
      .mplier  (mul_a_y),
      .done    (mul_a_done),
      .product (prod_a)
   );

   rar_mul u_mul_b (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (abs2),
      .mplier  (d1),
      .done    (mul_b_done),
      .product (prod_b)
   );

   rar_mul u_mul_c (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (d1),
      .mplier  (mul_c_y),
      .done    (mul_c_done),
      .product (prod_c)
   );

   // combine the cross products into sign and magnitude
   assign is_addsub = (cmd_ff == rar_pkg::CMD_ADD) || (cmd_ff == rar_pkg::CMD_SUB);
   assign sign_b    = neg2_ff ^ (cmd_ff == rar_pkg::CMD_SUB);

   always_comb begin
      if (!is_addsub) begin
         mag_c = rar_pkg::mag_type'(prod_a);
         neg_c = neg1_ff ^ neg2_ff;
      end else if (neg1_ff == sign_b) begin
         mag_c = rar_pkg::mag_type'(prod_a + prod_b);
         neg_c = neg1_ff;
      end else if (prod_a >= prod_b) begin
         mag_c = rar_pkg::mag_type'(prod_a - prod_b);
         neg_c = neg1_ff;
      end else begin
         mag_c = rar_pkg::mag_type'(prod_b - prod_a);
         neg_c = sign_b;
      end
   end

   assign den_c    = rar_pkg::mag_type'(prod_c);
   assign num_zero = (mag_c == '0);
   assign den_zero = (prod_c == '0);

   rar_gcd u_gcd (
      .clock  (clock),
      .reset  (reset),
      .start  (gcd_start),
      .x_init (mag_c),
      .y_init (den_c),
      .done   (gcd_done),
      .g      (gcd_g)
   );

   rar_div u_div_num (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mag_ff),
      .divisor  (gcd_g),
      .done     (div_n_done),
      .quotient (quo_n)
   );

   rar_div u_div_den (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (den_ff),
      .divisor  (gcd_g),
      .done     (div_d_done),
      .quotient (quo_d)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rar_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = rar_pkg::ST_MUL;
            end
         end
         rar_pkg::ST_MUL: begin
            if (mul_a_done && mul_b_done && mul_c_done) begin
               state_in = rar_pkg::ST_COMB;
            end
         end
         rar_pkg::ST_COMB: begin
            if (den_zero || num_zero) begin
               state_in = rar_pkg::ST_OUT;
            end else begin
               state_in = rar_pkg::ST_GCD;
            end
         end
         rar_pkg::ST_GCD: begin
            if (gcd_done) begin
               if (gcd_g > rar_pkg::mag_type'(1)) begin
                  state_in = rar_pkg::ST_DIV;
               end else begin
                  state_in = rar_pkg::ST_OUT;
               end
            end
         end
         rar_pkg::ST_DIV: begin
            if (div_n_done && div_d_done) begin
               state_in = rar_pkg::ST_OUT;
            end
         end
         rar_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = rar_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rar_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      mul_start = 1'b0;
      gcd_start = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         rar_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            mul_start = req_valid;
         end
         rar_pkg::ST_COMB: begin
            gcd_start = !den_zero && !num_zero;
         end
         rar_pkg::ST_GCD: begin
            div_start = gcd_done && (gcd_g > rar_pkg::mag_type'(1));
         end
         rar_pkg::ST_OUT: begin
            rsp_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rar_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign res_mag = red_ff ? quo_n : mag_ff;
   assign res_dm  = red_ff ? quo_d : den_ff;

   always_ff @(posedge clock) begin
      if (mul_start) begin
         cmd_ff  <= rar_pkg::cmd_type'(req_command);
         neg1_ff <= req_a_num[rar_pkg::OPERAND_W-1];
         neg2_ff <= req_b_num[rar_pkg::OPERAND_W-1];
      end
      if (state_ff == rar_pkg::ST_COMB) begin
         dz_ff  <= den_zero;
         red_ff <= 1'b0;
         if (den_zero || num_zero) begin
            mag_ff <= '0;
            den_ff <= rar_pkg::mag_type'(1);
            neg_ff <= 1'b0;
         end else begin
            mag_ff <= mag_c;
            den_ff <= den_c;
            neg_ff <= neg_c;
         end
      end
      if (div_start) begin
         red_ff <= 1'b1;
      end
      if (rsp_load) begin
         rsp_res_num_ff  <= neg_ff ? (rar_pkg::res_num_type'(0)
                                      - rar_pkg::res_num_type'(res_mag))
                                   : rar_pkg::res_num_type'(res_mag);
         rsp_res_den_ff  <= rar_pkg::res_den_type'(res_dm);
         rsp_reduced_ff  <= red_ff;
         rsp_div_zero_ff <= dz_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_res_num  = rsp_res_num_ff;
   assign rsp_res_den  = rsp_res_den_ff;
   assign rsp_reduced  = rsp_reduced_ff;
   assign rsp_div_zero = rsp_div_zero_ff;

   `RAR_ASSERT_IMPLIES(a_div_zero_result, clock, reset,
      rsp_valid_ff && rsp_div_zero_ff,
      rsp_res_num_ff == '0 && rsp_res_den_ff == rar_pkg::res_den_type'(1) && !rsp_reduced_ff)
   `RAR_ASSERT_NEXT(a_accept_starts_mul, clock, reset,
      req_valid && req_ready, state_ff == rar_pkg::ST_MUL)
   `RAR_ASSERT_IMPLIES(a_reduced_nonzero, clock, reset,
      rsp_valid_ff && rsp_reduced_ff, !rsp_div_zero_ff && rsp_res_num_ff != '0)
   `RAR_ASSERT_NEXT(a_out_holds, clock, reset,
      state_ff == rar_pkg::ST_OUT && rsp_valid_ff && !rsp_ready, state_ff == rar_pkg::ST_OUT)

endmodule

`default_nettype wire

>>> tb/rational_arith_reduce_test.sv
`default_nettype none

module rational_arith_reduce_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_WORDS = 1500;
   localparam int PHASE1_START = 520;
   localparam int PHASE2_START = 1020;
   localparam int HOLD_AT      = 1200;
   localparam int HOLD_CYCLES  = 600;
   localparam int TAIL_CYCLES  = 250;
   localparam int CYCLE_LIMIT  = 2000000;

   typedef struct {
      rar_pkg::cmd_type                     cmd;
      logic signed [rar_pkg::OPERAND_W-1:0] a_num;
      rar_pkg::den_type                     a_den;
      logic signed [rar_pkg::OPERAND_W-1:0] b_num;
      rar_pkg::den_type                     b_den;
      bit                                   drain;
   } operands_type;

   typedef struct packed {
      rar_pkg::res_num_type num;
      rar_pkg::res_den_type den;
      logic                 reduced;
      logic                 div_zero;
   } fraction_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   wire                  req_ready;
   logic [1:0]           req_command = rar_pkg::CMD_ADD;
   rar_pkg::operand_type req_a_num = '0;
   rar_pkg::den_type     req_a_den = '0;
   rar_pkg::operand_type req_b_num = '0;
   rar_pkg::den_type     req_b_den = '0;
   wire                  rsp_valid;
   logic                 rsp_ready = 1'b0;
   rar_pkg::res_num_type rsp_res_num;
   rar_pkg::res_den_type rsp_res_den;
   wire                  rsp_reduced;
   wire                  rsp_div_zero;

   operands_type pending_operands[$];
   fraction_type expected_fractions[$];
   operands_type on_bus;
   fraction_type got;
   fraction_type want;
   int           accepted = 0;
   int           mismatches = 0;
   int           hold_left = 0;
   bit           hold_done = 1'b0;
   int           cycle_count = 0;
   bit           load;

   rational_arith_reduce dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_command  (req_command),
      .req_a_num    (req_a_num),
      .req_a_den    (req_a_den),
      .req_b_num    (req_b_num),
      .req_b_den    (req_b_den),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_res_num  (rsp_res_num),
      .rsp_res_den  (rsp_res_den),
      .rsp_reduced  (rsp_reduced),
      .rsp_div_zero (rsp_div_zero)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic fraction_type reduced_fraction(operands_type w);
      longint          n1, d1, n2, d2, num, den, val;
      longint unsigned mag, dm, x, y, t;
      bit              neg;
      fraction_type    f;
      n1 = longint'(w.a_num);
      d1 = longint'(w.a_den);
      n2 = longint'(w.b_num);
      d2 = longint'(w.b_den);
      if (n1 == 0) d1 = 1;
      if (n2 == 0) d2 = 1;
      case (w.cmd)
         rar_pkg::CMD_ADD: begin
            num = n1 * d2 + n2 * d1;
            den = d1 * d2;
         end
         rar_pkg::CMD_SUB: begin
            num = n1 * d2 - n2 * d1;
            den = d1 * d2;
         end
         rar_pkg::CMD_MUL: begin
            num = n1 * n2;
            den = d1 * d2;
         end
         default: begin
            num = n1 * d2;
            den = d1 * n2;
         end
      endcase
      if (den == 0) begin
         f.num = '0;
         f.den = rar_pkg::res_den_type'(1);
         f.reduced = 1'b0;
         f.div_zero = 1'b1;
         return f;
      end
      if (den < 0) begin
         num = -num;
         den = -den;
      end
      if (num == 0) den = 1;
      neg = num < 0;
      mag = neg ? -num : num;
      dm = den;
      x = mag;
      y = dm;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      f.reduced = x > 1;
      if (x > 1) begin
         mag = mag / x;
         dm = dm / x;
      end
      val = neg ? -longint'(mag) : longint'(mag);
      f.num = val[31:0];
      f.den = dm[30:0];
      f.div_zero = 1'b0;
      return f;
   endfunction

   function automatic void queue_word(rar_pkg::cmd_type c, int an, int ad, int bn, int bd,
                                      bit drain);
      operands_type w;
      w.cmd = c;
      w.a_num = an[rar_pkg::OPERAND_W-1:0];
      w.a_den = ad[rar_pkg::DEN_W-1:0];
      w.b_num = bn[rar_pkg::OPERAND_W-1:0];
      w.b_den = bd[rar_pkg::DEN_W-1:0];
      w.drain = drain;
      pending_operands.push_back(w);
   endfunction

   function automatic int random_num();
      rar_pkg::operand_type raw;
      int                   corner[6] = '{-32768, 32767, 0, -1, 1, 16384};
      raw = rar_pkg::operand_type'($urandom());
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return int'($signed(raw));
         4, 5, 6:    return int'($urandom_range(0, 40)) - 20;
         7:          return (int'($urandom_range(0, 14)) - 7) << $urandom_range(0, 11);
         8:          return corner[$urandom_range(0, 5)];
         default:    return (int'($urandom_range(0, 200)) - 100) * 105;
      endcase
   endfunction

   function automatic int random_den();
      case ($urandom_range(0, 19))
         0:                      return 0;
         1, 2, 3, 4, 5, 6, 7:    return int'($urandom_range(1, 32767));
         8, 9, 10, 11, 12, 13:   return int'($urandom_range(1, 24));
         14, 15, 16:             return int'($urandom_range(1, 16)) * 105;
         17, 18:                 return 1 << $urandom_range(0, 14);
         default:                return 32767;
      endcase
   endfunction

   function automatic int idle_percent(bit sender, int done);
      if (done < PHASE1_START) return sender ? 10 : 81;
      if (done < PHASE2_START) return sender ? 81 : 10;
      return 0;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_fractions.push_back(reduced_fraction(on_bus));
            accepted <= accepted + 1;
         end
         if (!req_valid || req_ready) begin
            load = 1'b0;
            if (pending_operands.size() != 0 &&
                $urandom_range(0, 99) >= idle_percent(1'b1, accepted) &&
                (!pending_operands[0].drain || expected_fractions.size() == 0)) begin
               on_bus = pending_operands.pop_front();
               req_command <= on_bus.cmd;
               req_a_num <= on_bus.a_num;
               req_a_den <= on_bus.a_den;
               req_b_num <= on_bus.b_num;
               req_b_den <= on_bus.b_den;
               load = 1'b1;
            end
            req_valid <= load;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && accepted >= HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.num = rsp_res_num;
            got.den = rsp_res_den;
            got.reduced = rsp_reduced;
            got.div_zero = rsp_div_zero;
            if (expected_fractions.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected word: num %0d den %0d reduced %0b div_zero %0b",
                           $signed(got.num), got.den, got.reduced, got.div_zero);
            end else begin
               want = expected_fractions.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display(
                        "mismatch: want %0d/%0d red %0b dz %0b, got %0d/%0d red %0b dz %0b",
                        $signed(want.num), want.den, want.reduced, want.div_zero,
                        $signed(got.num), got.den, got.reduced, got.div_zero);
               end
            end
         end
         rsp_ready <= hold_left == 0 && $urandom_range(0, 99) >= idle_percent(1'b0, accepted);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      queue_word(rar_pkg::CMD_ADD, 1, 2, 1, 2, 1'b0);
      queue_word(rar_pkg::CMD_ADD, -32768, 32767, -32768, 32767, 1'b0);
      queue_word(rar_pkg::CMD_ADD, 32767, 1, 32767, 1, 1'b0);
      queue_word(rar_pkg::CMD_ADD, 1, 0, 1, 1, 1'b0);
      queue_word(rar_pkg::CMD_ADD, 12, 32767, -12, 1, 1'b0);
      queue_word(rar_pkg::CMD_SUB, 5, 7, 5, 7, 1'b0);
      queue_word(rar_pkg::CMD_SUB, -32768, 1, 32767, 1, 1'b0);
      queue_word(rar_pkg::CMD_SUB, 0, 0, 0, 0, 1'b0);
      queue_word(rar_pkg::CMD_SUB, 1, 32767, 1, 16384, 1'b0);
      queue_word(rar_pkg::CMD_MUL, -32768, 1, -32768, 1, 1'b0);
      queue_word(rar_pkg::CMD_MUL, 6, 4, 10, 9, 1'b0);
      queue_word(rar_pkg::CMD_MUL, 0, 32767, 123, 45, 1'b0);
      queue_word(rar_pkg::CMD_MUL, 3, 0, 4, 5, 1'b0);
      queue_word(rar_pkg::CMD_MUL, -1, 32767, 1, 32767, 1'b0);
      queue_word(rar_pkg::CMD_DIV, 1, 2, 0, 5, 1'b0);
      queue_word(rar_pkg::CMD_DIV, 7, 3, -14, 9, 1'b0);
      queue_word(rar_pkg::CMD_DIV, -32768, 32767, -32768, 32767, 1'b0);
      queue_word(rar_pkg::CMD_DIV, 32767, 1, -32768, 32767, 1'b0);
      queue_word(rar_pkg::CMD_DIV, 0, 5, 3, 4, 1'b0);
      queue_word(rar_pkg::CMD_DIV, 32767, 32767, 1, 1, 1'b0);
      queue_word(rar_pkg::CMD_DIV, 1, 1, 1, 0, 1'b0);
      for (int i = 0; i < RANDOM_WORDS; i++)
         queue_word(rar_pkg::cmd_type'($urandom_range(0, 3)), random_num(), random_den(),
                    random_num(), random_den(),
                    i == 0 || i == 500 || i == 750 || i == 1000);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      while (pending_operands.size() != 0 || req_valid) @(posedge clock);
      while (expected_fractions.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_fractions.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire
